@@ rtl/tea_pkg.sv @@
// Shared widths, command and status codes, and sequencer states of the timetable block.
package tea_pkg;

	localparam int ID_W       = 16;
	localparam int TIME_W     = 17;
	localparam int CELL_W     = TIME_W + 1;
	localparam int ROW_W      = 6;
	localparam int COL_W      = 8;
	localparam int CMD_W      = 2;
	localparam int STAT_W     = 2;
	localparam int S_TDATA_W  = 88;
	localparam int M_TDATA_W  = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int STN_REG_W  = 7;
	localparam int TRP_REG_W  = 9;

	localparam logic [CMD_W-1:0] CMD_WR_SLOT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WR_CELL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ARRIVAL = 2'd2;
	localparam logic [CMD_W-1:0] CMD_ORDER   = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_FIRST   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NO_SECOND  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_SAME       = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_STATIONS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIPS    = 2'd1;

	typedef enum logic [3:0] {
		SEQ_IDLE   = 4'b0001,
		SEQ_SLOTS  = 4'b0010,
		SEQ_TRIPS  = 4'b0100,
		SEQ_FINISH = 4'b1000
	} seq_state_t;

endpackage

@@ rtl/timetable_earliest_arrival.sv @@
// Top level of the timetable earliest-arrival block: stores, sequencer and result register.

// The block keeps an ordered list of station identifiers and a timetable of optional times
// (one row per station slot, one column per trip), both loaded by write transfers on the
// input stream, and answers earliest-arrival and station-order queries with one result
// transfer per input transfer. An order query reads each station slot in use from the
// identifier memory once, one slot per cycle, then takes the last read and makes the
// decision. An arrival query then also walks the trip columns, one column per cycle through
// the timetable memory, which reads the start and end rows of a column together; it stops
// early at the first hit. The input is not ready while a query is in progress, but a new
// transfer is taken while the previous result still waits on the output. Entries never
// written read as garbage.
module timetable_earliest_arrival #(
	parameter int MAX_STATIONS = 64,
	parameter int MAX_TRIPS    = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port.
	input  logic                              cfg_wen,
	input  logic [tea_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tea_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	// Input stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// From bit 0: row_slot[5:0], trip_column[13:6], station_id[29:14],
	// other_station_id[45:30], cell_present[46], cell_time[63:47],
	// earliest_departure[80:64], zero fill.
	input  logic [tea_pkg::S_TDATA_W-1:0]     s_tdata,
	// command[1:0]
	input  logic [tea_pkg::CMD_W-1:0]         s_tuser,
	// Result stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// From bit 0: found[0], arrival_time[17:1], first_precedes[18], zero fill.
	output logic [tea_pkg::M_TDATA_W-1:0]     m_tdata,
	// status[1:0]
	output logic [tea_pkg::STAT_W-1:0]        m_tuser
);
	import tea_pkg::*;

	localparam int SW  = $clog2(MAX_STATIONS);
	localparam int TW  = (MAX_TRIPS > 1) ? $clog2(MAX_TRIPS) : 1;
	localparam int CW  = $clog2(MAX_STATIONS + 1);
	localparam int TCW = $clog2(MAX_TRIPS + 1);
	localparam int RXW = (SW > ROW_W) ? SW : ROW_W;
	localparam int CXW = (TW > COL_W) ? TW : COL_W;
	localparam int CELL_DEPTH = MAX_STATIONS * (2 ** TW);

	// Unpacked input fields.
	logic [ROW_W-1:0]  in_row;
	logic [COL_W-1:0]  in_col;
	logic [ID_W-1:0]   in_id_a;
	logic [ID_W-1:0]   in_id_b;
	logic              in_present;
	logic [TIME_W-1:0] in_time;
	logic [TIME_W-1:0] in_depart;

	assign in_row     = s_tdata[5:0];
	assign in_col     = s_tdata[13:6];
	assign in_id_a    = s_tdata[29:14];
	assign in_id_b    = s_tdata[45:30];
	assign in_present = s_tdata[46];
	assign in_time    = s_tdata[63:47];
	assign in_depart  = s_tdata[80:64];

	// Configuration registers.
	logic [STN_REG_W-1:0] stations_in_use_q;
	logic [TRP_REG_W-1:0] trips_in_use_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stations_in_use_q <= '0;
			trips_in_use_q    <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_STATIONS: stations_in_use_q <= cfg_wdata[STN_REG_W-1:0];
				REG_TRIPS:    trips_in_use_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Register values beyond the store size saturate at the store size.
	logic [CW-1:0]  stn_count;
	logic [TCW-1:0] trip_count;

	assign stn_count  = (32'(stations_in_use_q) > MAX_STATIONS) ? CW'(MAX_STATIONS)
	                                                            : CW'(stations_in_use_q);
	assign trip_count = (32'(trips_in_use_q) > MAX_TRIPS) ? TCW'(MAX_TRIPS)
	                                                      : TCW'(trips_in_use_q);

	// Sequencer and work registers.
	seq_state_t        state_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [ID_W-1:0]   id_a_q;
	logic [ID_W-1:0]   id_b_q;
	logic [TIME_W-1:0] depart_q;
	logic [CW-1:0]     slot_q;
	logic [TCW-1:0]    trip_q;
	logic              have_a_q;
	logic              have_b_q;
	logic [SW-1:0]     sa_q;
	logic [SW-1:0]     sb_q;

	// Memory read pipeline.
	logic              sv_s1;
	logic [SW-1:0]     slot_s1;
	logic [ID_W-1:0]   id_rd_s1;
	logic              tv_s1;
	logic [CELL_W-1:0] start_cell_s1;
	logic [CELL_W-1:0] end_cell_s1;

	// Pending result.
	logic [STAT_W-1:0] res_status_q;
	logic              res_found_q;
	logic [TIME_W-1:0] res_arrival_q;
	logic              res_precedes_q;

	// Output register.
	logic                 m_tvalid_q;
	logic [STAT_W-1:0]    m_status_q;
	logic                 m_found_q;
	logic [TIME_W-1:0]    m_arrival_q;
	logic                 m_precedes_q;

	logic in_xfer;
	assign s_tready = (state_q == SEQ_IDLE);
	assign in_xfer  = s_tvalid && s_tready;

	// Write decode, with out-of-store rows and columns dropped.
	logic [RXW-1:0] row_ext;
	logic [CXW-1:0] col_ext;
	logic           row_ok;
	logic           col_ok;
	logic           slot_we;
	logic           cell_we;

	assign row_ext = RXW'(in_row);
	assign col_ext = CXW'(in_col);
	assign row_ok  = 32'(in_row) < MAX_STATIONS;
	assign col_ok  = 32'(in_col) < MAX_TRIPS;
	assign slot_we = in_xfer && (s_tuser == CMD_WR_SLOT) && row_ok;
	assign cell_we = in_xfer && (s_tuser == CMD_WR_CELL) && row_ok && col_ok;

	// Station identifier memory: one write port and one read port.
	logic [ID_W-1:0] station_mem [MAX_STATIONS];

	always_ff @(posedge clk) begin
		if (slot_we) begin
			station_mem[row_ext[SW-1:0]] <= in_id_a;
		end
		id_rd_s1 <= station_mem[slot_q[SW-1:0]];
	end

	// Timetable memory: one write port, two read ports for the start and end rows.
	// Row and column form the address directly; columns are padded to a power of two.
	logic [CELL_W-1:0] cell_mem [CELL_DEPTH];

	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem[{row_ext[SW-1:0], col_ext[TW-1:0]}] <= {in_present, in_time};
		end
		start_cell_s1 <= cell_mem[{sa_q, trip_q[TW-1:0]}];
		end_cell_s1   <= cell_mem[{sb_q, trip_q[TW-1:0]}];
	end

	// A trip is a hit when both times are present and the start is not before departure.
	logic trip_hit;
	assign trip_hit = tv_s1 && start_cell_s1[TIME_W] && (start_cell_s1[TIME_W-1:0] >= depart_q)
	                  && end_cell_s1[TIME_W];

	logic slot_match_a;
	logic slot_match_b;
	assign slot_match_a = sv_s1 && !have_a_q && (id_rd_s1 == id_a_q);
	assign slot_match_b = sv_s1 && !have_b_q && (id_rd_s1 == id_b_q);

	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= SEQ_IDLE;
			cmd_q          <= CMD_WR_SLOT;
			slot_q         <= '0;
			trip_q         <= '0;
			have_a_q       <= 1'b0;
			have_b_q       <= 1'b0;
			sa_q           <= '0;
			sb_q           <= '0;
			sv_s1          <= 1'b0;
			tv_s1          <= 1'b0;
			res_status_q   <= STAT_OK;
			res_found_q    <= 1'b0;
			res_arrival_q  <= '0;
			res_precedes_q <= 1'b0;
		end else begin
			unique case (state_q)
				SEQ_IDLE: begin
					sv_s1 <= 1'b0;
					tv_s1 <= 1'b0;
					if (in_xfer) begin
						cmd_q          <= s_tuser;
						res_status_q   <= STAT_OK;
						res_found_q    <= 1'b0;
						res_arrival_q  <= '0;
						res_precedes_q <= 1'b0;
						have_a_q       <= 1'b0;
						have_b_q       <= 1'b0;
						slot_q         <= '0;
						if (s_tuser == CMD_ARRIVAL || s_tuser == CMD_ORDER) begin
							state_q <= SEQ_SLOTS;
						end else begin
							state_q <= SEQ_FINISH;
						end
					end
				end
				SEQ_SLOTS: begin
					// Walk the slots in use; the first match wins for each identifier.
					if (slot_match_a) begin
						have_a_q <= 1'b1;
						sa_q     <= slot_s1;
					end
					if (slot_match_b) begin
						have_b_q <= 1'b1;
						sb_q     <= slot_s1;
					end
					if (slot_q < stn_count) begin
						sv_s1  <= 1'b1;
						slot_q <= slot_q + 1'b1;
					end else begin
						sv_s1 <= 1'b0;
					end
					if (slot_q == stn_count && !sv_s1) begin
						if (!have_a_q) begin
							res_status_q <= STAT_NO_FIRST;
							state_q      <= SEQ_FINISH;
						end else if (!have_b_q) begin
							res_status_q <= STAT_NO_SECOND;
							state_q      <= SEQ_FINISH;
						end else if (cmd_q == CMD_ORDER) begin
							if (sa_q == sb_q) begin
								res_status_q <= STAT_SAME;
							end else begin
								res_precedes_q <= (sa_q < sb_q);
							end
							state_q <= SEQ_FINISH;
						end else if (sa_q <= sb_q) begin
							trip_q  <= '0;
							state_q <= SEQ_TRIPS;
						end else begin
							// Start station lies after the end station: nothing to find.
							state_q <= SEQ_FINISH;
						end
					end
				end
				SEQ_TRIPS: begin
					if (trip_hit) begin
						res_found_q   <= 1'b1;
						res_arrival_q <= end_cell_s1[TIME_W-1:0];
						tv_s1         <= 1'b0;
						state_q       <= SEQ_FINISH;
					end else begin
						if (trip_q < trip_count) begin
							tv_s1  <= 1'b1;
							trip_q <= trip_q + 1'b1;
						end else begin
							tv_s1 <= 1'b0;
						end
						if (trip_q == trip_count && !tv_s1) begin
							state_q <= SEQ_FINISH;
						end
					end
				end
				SEQ_FINISH: begin
					sv_s1 <= 1'b0;
					tv_s1 <= 1'b0;
					if (out_free) begin
						state_q <= SEQ_IDLE;
					end
				end
				default: state_q <= SEQ_IDLE;
			endcase
		end
	end

	// Payload of the slot pipeline and the query operands carry no reset.
	always_ff @(posedge clk) begin
		slot_s1 <= slot_q[SW-1:0];
		if (in_xfer) begin
			id_a_q   <= in_id_a;
			id_b_q   <= in_id_b;
			depart_q <= in_depart;
		end
	end

	// Output register: loaded from the pending result once the previous one has left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == SEQ_FINISH && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SEQ_FINISH && out_free) begin
			m_status_q   <= res_status_q;
			m_found_q    <= res_found_q;
			m_arrival_q  <= res_arrival_q;
			m_precedes_q <= res_precedes_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {5'b0, m_precedes_q, m_arrival_q, m_found_q};

endmodule

@@ rtl/tea_checker.sv @@
// Port-level assertions for the timetable earliest-arrival block, with its bind.
module tea_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [tea_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [tea_pkg::STAT_W-1:0]    m_tuser
);
	import tea_pkg::*;

	// A result that is not taken stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Every accepted item keeps the block busy for at least the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a transfer");

	// An error status carries neither a found time nor an order answer.
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != STAT_OK) |-> !m_tdata[0] && !m_tdata[18])
		else $error("error result with answer bits set");

	// Without a found time the arrival field is zero.
	a_arr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> (m_tdata[17:1] == '0))
		else $error("arrival time without found");

	// Arrival and order answers never appear in the same result.
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[18]))
		else $error("found and precedes both set");

endmodule

bind timetable_earliest_arrival tea_checker u_tea_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
